### rtl/core/bbcf_pkg.sv
// Shared constants, types and helper functions of the black border crop finder.
`default_nettype none

package bbcf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W  = 8;
  localparam int SIZE_W = 12;
  localparam int OUT_W  = 14;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CCNT_W = COL_W + 1;
  localparam int RCNT_W = ROW_W + 1;
  localparam int RPT_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic REQ_PIXEL  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 8'd200;
  localparam logic [SIZE_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 12'd480;

  typedef struct packed {
    logic             valid;
    logic             report;
    logic             dark;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             first_row;
    logic             last_col;
    logic             last_row;
  } stage1_t;

  // Zero acts as one, and anything above the maximum saturates.
  function automatic logic [CCNT_W-1:0] eff_width(input logic [SIZE_W-1:0] v);
    logic [CCNT_W-1:0] res;
    if (v == '0) begin
      res = CCNT_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = CCNT_W'(MAX_WIDTH);
    end else begin
      res = CCNT_W'(v);
    end
    return res;
  endfunction

  function automatic logic [RCNT_W-1:0] eff_height(input logic [SIZE_W-1:0] v);
    logic [RCNT_W-1:0] res;
    if (v == '0) begin
      res = RCNT_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      res = RCNT_W'(MAX_HEIGHT);
    end else begin
      res = RCNT_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bbcf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bbcf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/black_border_crop_finder_top.sv
// Black border crop finder: per-column dark flags in a RAM, frame-end border
// tracking and a pipelined square crop report.
//
// Usage: configuration writes (threshold, width, height) go through the cfg
// channel, which is always ready; a size write restarts the frame and reloads
// the borders. The user must write configuration only while the block is idle;
// the block does not enforce it. Input items are pixels in raster order
// (in_req_type = 0) or report requests (in_req_type = 1). A pixel produces no
// result; a report produces one registered out item. Throughput is one item
// per cycle unless the receiver stalls. Each pixel does a read-modify-write of
// its column flag in the flag RAM: read when the item is accepted, written as
// it leaves stage 1, with forwarding when the next pixel falls on the same
// column. Reset clears the positions, the frame flags and reloads the borders
// for a 640 by 480 frame; the flag RAM needs no clearing since the first row
// of each frame overwrites it. When a report waits in the output register and
// the receiver stalls, the whole pipeline holds and in_ready goes low.
`default_nettype none

module black_border_crop_finder_top
  import bbcf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [PIX_W-1:0]     in_red,
  input  wire logic [PIX_W-1:0]     in_green,
  input  wire logic [PIX_W-1:0]     in_blue,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [OUT_W-1:0]   out_crop_width,
  output logic signed [OUT_W-1:0]   out_crop_height,
  output logic signed [OUT_W-1:0]   out_crop_left,
  output logic signed [OUT_W-1:0]   out_crop_top
);

  // Configuration registers.
  logic [PIX_W-1:0]  threshold_r, threshold_nxt;
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;

  // Frame position and per-frame tracking.
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              row_dark_r, row_dark_nxt;
  logic              rows_open_r, rows_open_nxt;
  logic [RCNT_W-1:0] lead_rows_r, lead_rows_nxt;
  logic [RCNT_W-1:0] bright_row_p1_r, bright_row_p1_nxt;
  logic              cols_open_r, cols_open_nxt;
  logic [CCNT_W-1:0] lead_cols_r, lead_cols_nxt;
  logic [CCNT_W-1:0] bright_col_p1_r, bright_col_p1_nxt;

  // Borders kept over all frames.
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  bottom_r, bottom_nxt;
  logic [COL_W-1:0]  left_r, left_nxt;
  logic [COL_W-1:0]  right_r, right_nxt;

  // Pipeline.
  stage1_t           s1_r, s1_nxt;
  logic              fwd_r, fwd_nxt;
  logic              fwd_data_r, fwd_data_nxt;
  logic              s2_valid_r, s2_valid_nxt;
  logic signed [RPT_W-1:0] s2_cx_r, s2_cy_r, s2_w_r, s2_h_r;
  logic              out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_side_r, out_left_r, out_top_r;

  logic              adv;
  logic              in_acc;
  logic              pix_acc;
  logic              cfg_acc;
  logic [CCNT_W-1:0] eff_w;
  logic [RCNT_W-1:0] eff_h;
  logic [CCNT_W-1:0] cfg_eff_w;
  logic [RCNT_W-1:0] cfg_eff_h;
  logic              in_dark;
  logic              in_last_col;
  logic              in_last_row;

  logic              ram_rdata;
  logic              col_flag;
  logic              coldark;
  logic              commit;
  logic              row_dark_now;

  logic signed [RPT_W-1:0] rep_l, rep_t, rep_b, rep_r;
  logic signed [RPT_W-1:0] rep_sum_x, rep_sum_y;
  logic signed [RPT_W-1:0] side, side_adj, half;
  logic signed [RPT_W-1:0] crop_left, crop_top;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign pix_acc   = in_acc && (in_req_type == REQ_PIXEL);
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign eff_w     = eff_width(width_r);
  assign eff_h     = eff_height(height_r);
  assign cfg_eff_w = eff_width(cfg_data);
  assign cfg_eff_h = eff_height(cfg_data);

  assign in_dark = (in_red <= threshold_r) && (in_green <= threshold_r)
                   && (in_blue <= threshold_r);
  assign in_last_col = (CCNT_W'(col_r) + CCNT_W'(1)) >= eff_w;
  assign in_last_row = (RCNT_W'(row_r) + RCNT_W'(1)) >= eff_h;

  bbcf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_col_flags (
    .clk   (clk),
    .we    (commit),
    .waddr (s1_r.col),
    .wdata (coldark),
    .re    (pix_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Stage 1: finish the column flag and update the frame tracking.
  assign commit       = s1_r.valid && !s1_r.report && adv;
  assign col_flag     = fwd_r ? fwd_data_r : ram_rdata;
  assign coldark      = s1_r.first_row ? s1_r.dark : (s1_r.dark && col_flag);
  assign row_dark_now = row_dark_r && s1_r.dark;

  always_comb begin
    threshold_nxt     = threshold_r;
    width_nxt         = width_r;
    height_nxt        = height_r;
    col_nxt           = col_r;
    row_nxt           = row_r;
    row_dark_nxt      = row_dark_r;
    rows_open_nxt     = rows_open_r;
    lead_rows_nxt     = lead_rows_r;
    bright_row_p1_nxt = bright_row_p1_r;
    cols_open_nxt     = cols_open_r;
    lead_cols_nxt     = lead_cols_r;
    bright_col_p1_nxt = bright_col_p1_r;
    top_nxt           = top_r;
    bottom_nxt        = bottom_r;
    left_nxt          = left_r;
    right_nxt         = right_r;

    if (cfg_acc) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold_nxt = cfg_data[PIX_W-1:0];
        CFG_WIDTH: begin
          width_nxt = cfg_data;
        end
        CFG_HEIGHT: begin
          height_nxt = cfg_data;
        end
        default: ;
      endcase
      if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT) begin
        col_nxt           = '0;
        row_nxt           = '0;
        row_dark_nxt      = 1'b1;
        rows_open_nxt     = 1'b1;
        lead_rows_nxt     = '0;
        bright_row_p1_nxt = '0;
        cols_open_nxt     = 1'b1;
        lead_cols_nxt     = '0;
        bright_col_p1_nxt = '0;
        top_nxt           = '0;
        left_nxt          = '0;
        if (cfg_index == CFG_WIDTH) begin
          right_nxt  = COL_W'(cfg_eff_w - CCNT_W'(1));
          bottom_nxt = ROW_W'(eff_h - RCNT_W'(1));
        end else begin
          right_nxt  = COL_W'(eff_w - CCNT_W'(1));
          bottom_nxt = ROW_W'(cfg_eff_h - RCNT_W'(1));
        end
      end
    end else begin
      if (pix_acc) begin
        col_nxt = in_last_col ? '0 : col_r + COL_W'(1);
        if (in_last_col) begin
          row_nxt = in_last_row ? '0 : row_r + ROW_W'(1);
        end
      end

      if (commit) begin
        if (s1_r.last_row) begin
          if (coldark) begin
            if (cols_open_r) begin
              lead_cols_nxt = lead_cols_r + CCNT_W'(1);
            end
          end else begin
            cols_open_nxt     = 1'b0;
            bright_col_p1_nxt = CCNT_W'(s1_r.col) + CCNT_W'(1);
          end
        end
        if (!s1_r.dark) begin
          row_dark_nxt = 1'b0;
        end

        if (s1_r.last_col) begin
          row_dark_nxt = 1'b1;
          if (row_dark_now) begin
            if (rows_open_r) begin
              lead_rows_nxt = lead_rows_r + RCNT_W'(1);
            end
          end else begin
            rows_open_nxt     = 1'b0;
            bright_row_p1_nxt = RCNT_W'(s1_r.row) + RCNT_W'(1);
          end

          // Frame end: widen the borders, then start the next frame.
          if (s1_r.last_row) begin
            if (lead_rows_nxt != '0
                && (lead_rows_nxt - RCNT_W'(1)) > RCNT_W'(top_r)) begin
              top_nxt = ROW_W'(lead_rows_nxt - RCNT_W'(1));
            end
            if (bright_row_p1_nxt < eff_h
                && bright_row_p1_nxt < RCNT_W'(bottom_r)) begin
              bottom_nxt = ROW_W'(bright_row_p1_nxt);
            end
            if (lead_cols_nxt != '0
                && (lead_cols_nxt - CCNT_W'(1)) > CCNT_W'(left_r)) begin
              left_nxt = COL_W'(lead_cols_nxt - CCNT_W'(1));
            end
            if (bright_col_p1_nxt < eff_w
                && bright_col_p1_nxt < CCNT_W'(right_r)) begin
              right_nxt = COL_W'(bright_col_p1_nxt);
            end
            row_dark_nxt      = 1'b1;
            rows_open_nxt     = 1'b1;
            lead_rows_nxt     = '0;
            bright_row_p1_nxt = '0;
            cols_open_nxt     = 1'b1;
            lead_cols_nxt     = '0;
            bright_col_p1_nxt = '0;
          end
        end
      end
    end
  end

  // Stage 0 to stage 1 handoff, with forwarding when the pixel just read
  // hits the column that stage 1 writes at the same edge.
  always_comb begin
    s1_nxt       = s1_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    if (adv) begin
      s1_nxt.valid     = in_acc;
      s1_nxt.report    = (in_req_type == REQ_REPORT);
      s1_nxt.dark      = in_dark;
      s1_nxt.col       = col_r;
      s1_nxt.row       = row_r;
      s1_nxt.first_row = (row_r == '0);
      s1_nxt.last_col  = in_last_col;
      s1_nxt.last_row  = in_last_row;
      fwd_nxt          = pix_acc && commit && (s1_r.col == col_r);
      fwd_data_nxt     = coldark;
    end
  end

  // Report arithmetic, split over stage 1 and stage 2.
  assign rep_l     = RPT_W'(left_r) + RPT_W'(1);
  assign rep_t     = RPT_W'(top_r) + RPT_W'(1);
  assign rep_b     = RPT_W'(bottom_r) - RPT_W'(1);
  assign rep_r     = RPT_W'(right_r) - RPT_W'(1);
  assign rep_sum_x = rep_l + rep_r;
  assign rep_sum_y = rep_t + rep_b;

  // Halving of a negative side must truncate toward zero.
  assign side      = (s2_w_r < s2_h_r) ? s2_w_r : s2_h_r;
  assign side_adj  = side + (side[RPT_W-1] ? RPT_W'(1) : RPT_W'(0));
  assign half      = side_adj >>> 1;
  assign crop_left = s2_cx_r - half;
  assign crop_top  = s2_cy_r - half;

  assign s2_valid_nxt  = adv ? (s1_r.valid && s1_r.report) : s2_valid_r;
  assign out_valid_nxt = adv ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RESET;
      width_r         <= WIDTH_RESET;
      height_r        <= HEIGHT_RESET;
      col_r           <= '0;
      row_r           <= '0;
      row_dark_r      <= 1'b1;
      rows_open_r     <= 1'b1;
      lead_rows_r     <= '0;
      bright_row_p1_r <= '0;
      cols_open_r     <= 1'b1;
      lead_cols_r     <= '0;
      bright_col_p1_r <= '0;
      top_r           <= '0;
      left_r          <= '0;
      bottom_r        <= ROW_W'(eff_height(HEIGHT_RESET) - RCNT_W'(1));
      right_r         <= COL_W'(eff_width(WIDTH_RESET) - CCNT_W'(1));
      s1_r            <= '0;
      fwd_r           <= 1'b0;
      s2_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      threshold_r     <= threshold_nxt;
      width_r         <= width_nxt;
      height_r        <= height_nxt;
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      row_dark_r      <= row_dark_nxt;
      rows_open_r     <= rows_open_nxt;
      lead_rows_r     <= lead_rows_nxt;
      bright_row_p1_r <= bright_row_p1_nxt;
      cols_open_r     <= cols_open_nxt;
      lead_cols_r     <= lead_cols_nxt;
      bright_col_p1_r <= bright_col_p1_nxt;
      top_r           <= top_nxt;
      left_r          <= left_nxt;
      bottom_r        <= bottom_nxt;
      right_r         <= right_nxt;
      s1_r            <= s1_nxt;
      fwd_r           <= fwd_nxt;
      s2_valid_r      <= s2_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fwd_data_r     <= fwd_data_nxt;
    if (adv) begin
      s2_cx_r    <= rep_sum_x >>> 1;
      s2_cy_r    <= rep_sum_y >>> 1;
      s2_w_r     <= rep_r - rep_l;
      s2_h_r     <= rep_b - rep_t;
      out_side_r <= OUT_W'(side);
      out_left_r <= OUT_W'(crop_left);
      out_top_r  <= OUT_W'(crop_top);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_crop_width  = out_side_r;
  assign out_crop_height = out_side_r;
  assign out_crop_left   = out_left_r;
  assign out_crop_top    = out_top_r;

`ifndef SYNTH
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    CCNT_W'(col_r) < eff_w)
    else $error("column position beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    RCNT_W'(row_r) < eff_h)
    else $error("row position beyond frame height");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r && s1_r.valid |-> $past(s1_r.valid) && !$past(s1_r.report))
    else $error("flag forwarding without a pixel committing before");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without a waiting result");
`endif

endmodule

`default_nettype wire

### sim/black_border_crop_finder_top_test.sv
// Self-checking testbench for the black border crop finder: directed table, then random frames.
module black_border_crop_finder_top_test;
  import bbcf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 560;
  localparam int FRAME_LEN = 160;

  typedef struct packed {
    logic signed [OUT_W-1:0] width;
    logic signed [OUT_W-1:0] height;
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] top;
  } crop_t;

  typedef enum {STEP_WRITE, STEP_PIXEL, STEP_REPORT} step_kind_t;

  typedef struct {
    step_kind_t kind;
    int         a;
    int         b;
    int         c;
    bit         typed;
    crop_t      want;
  } script_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [PIX_W-1:0]     in_red;
  logic [PIX_W-1:0]     in_green;
  logic [PIX_W-1:0]     in_blue;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_crop_width;
  logic signed [OUT_W-1:0] out_crop_height;
  logic signed [OUT_W-1:0] out_crop_left;
  logic signed [OUT_W-1:0] out_crop_top;

  black_border_crop_finder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_crop_width (out_crop_width),
    .out_crop_height(out_crop_height),
    .out_crop_left  (out_crop_left),
    .out_crop_top   (out_crop_top)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Border tracker state, mirrored from the block's behavior.
  logic [PIX_W-1:0]  thr;
  logic [SIZE_W-1:0] fw;
  logic [SIZE_W-1:0] fh;
  bit  col_dark [0:MAX_WIDTH-1];
  int  col_pos;
  int  row_pos;
  bit  row_dark;
  bit  rows_open;
  int  lead_rows;
  int  last_bright_row;
  bit  cols_open;
  int  lead_cols;
  int  last_bright_col;
  int  top_b;
  int  bot_b;
  int  left_b;
  int  right_b;

  crop_t pending_crops[$];
  script_row_t script[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  hold_req = 0;
  bit  sender_quiet = 1'b0;
  bit  receiver_quiet = 1'b0;

  // Bright window of the frame being generated.
  int  win_l;
  int  win_r;
  int  win_t;
  int  win_b;

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    row_dark = 1'b1;
    rows_open = 1'b1;
    lead_rows = 0;
    last_bright_row = -1;
    cols_open = 1'b1;
    lead_cols = 0;
    last_bright_col = -1;
  endfunction

  function automatic void reload_borders();
    top_b = 0;
    left_b = 0;
    bot_b = clamp_size(fh, MAX_HEIGHT) - 1;
    right_b = clamp_size(fw, MAX_WIDTH) - 1;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    case (idx)
      CFG_THRESHOLD: thr = data[PIX_W-1:0];
      CFG_WIDTH: begin
        fw = data;
        restart_frame();
        reload_borders();
      end
      CFG_HEIGHT: begin
        fh = data;
        restart_frame();
        reload_borders();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                        logic [PIX_W-1:0] b);
    int w;
    int h;
    int c;
    bit dark;
    bit coldark;
    bit last_row;
    w = clamp_size(fw, MAX_WIDTH);
    h = clamp_size(fh, MAX_HEIGHT);
    c = col_pos % MAX_WIDTH;
    dark = (r <= thr) && (g <= thr) && (b <= thr);
    coldark = (row_pos == 0) ? dark : (dark && col_dark[c]);
    last_row = (row_pos + 1 >= h);
    col_dark[c] = coldark;
    if (!dark) row_dark = 1'b0;
    // Column runs are judged on the last row, where each flag covers the whole column.
    if (last_row) begin
      if (coldark) begin
        if (cols_open) lead_cols++;
      end else begin
        cols_open = 1'b0;
        last_bright_col = c;
      end
    end
    if (col_pos + 1 < w) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    if (row_dark) begin
      if (rows_open) lead_rows++;
    end else begin
      rows_open = 1'b0;
      last_bright_row = row_pos;
    end
    row_dark = 1'b1;
    if (!last_row) begin
      row_pos++;
      return;
    end
    if (lead_rows > 0 && lead_rows - 1 > top_b) top_b = lead_rows - 1;
    if (last_bright_row + 1 < h && last_bright_row + 1 < bot_b) bot_b = last_bright_row + 1;
    if (lead_cols > 0 && lead_cols - 1 > left_b) left_b = lead_cols - 1;
    if (last_bright_col + 1 < w && last_bright_col + 1 < right_b) right_b = last_bright_col + 1;
    restart_frame();
  endfunction

  function automatic crop_t predict_crop();
    int l;
    int t;
    int b;
    int r;
    int cx;
    int cy;
    int side;
    crop_t res;
    l = left_b + 1;
    t = top_b + 1;
    b = bot_b - 1;
    r = right_b - 1;
    cx = (l + r) / 2;
    cy = (t + b) / 2;
    side = ((r - l) < (b - t)) ? (r - l) : (b - t);
    res.width = OUT_W'(side);
    res.height = OUT_W'(side);
    res.left = OUT_W'(cx - side / 2);
    res.top = OUT_W'(cy - side / 2);
    return res;
  endfunction

  // Frames are mostly a bright rectangle on a dark surround, with a little noise.
  function automatic void make_pixel(output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                                     output logic [PIX_W-1:0] b);
    int w;
    int h;
    bit bright;
    w = clamp_size(fw, MAX_WIDTH);
    h = clamp_size(fh, MAX_HEIGHT);
    if (col_pos == 0 && row_pos == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          win_l = w;
          win_r = -1;
          win_t = h;
          win_b = -1;
        end
        1: begin
          win_l = 0;
          win_r = w - 1;
          win_t = 0;
          win_b = h - 1;
        end
        default: begin
          win_l = $urandom_range(0, w - 1);
          win_r = $urandom_range(win_l, w - 1);
          win_t = $urandom_range(0, h - 1);
          win_b = $urandom_range(win_t, h - 1);
        end
      endcase
    end
    bright = col_pos >= win_l && col_pos <= win_r && row_pos >= win_t && row_pos <= win_b;
    if ($urandom_range(0, 15) == 0) bright = !bright;
    r = PIX_W'($urandom_range(0, thr));
    g = PIX_W'($urandom_range(0, thr));
    b = PIX_W'($urandom_range(0, thr));
    if (bright && thr != 8'hFF) begin
      case ($urandom_range(0, 2))
        0: r = PIX_W'($urandom_range(thr + 1, 255));
        1: g = PIX_W'($urandom_range(thr + 1, 255));
        default: b = PIX_W'($urandom_range(thr + 1, 255));
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      r = PIX_W'($urandom);
      g = PIX_W'($urandom);
      b = PIX_W'($urandom);
    end
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return SIZE_W'($urandom_range(7, 40));
      2: return SIZE_W'($urandom_range(2049, 4095));
      default: return SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic void put(step_kind_t k, int a, int b, int c, bit typed,
                              int ew, int el, int et);
    script_row_t s;
    s.kind = k;
    s.a = a;
    s.b = b;
    s.c = c;
    s.typed = typed;
    s.want.width = OUT_W'(ew);
    s.want.height = OUT_W'(ew);
    s.want.left = OUT_W'(el);
    s.want.top = OUT_W'(et);
    script.push_back(s);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic req, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                           logic [PIX_W-1:0] b, bit typed, crop_t want);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req == REQ_REPORT) begin
      pending_crops.push_back(typed ? want : predict_crop());
    end else begin
      predict_pixel(r, g, b);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_crops.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    wait_drained();
    // Pixels leave no result behind, so give the pipeline time to empty.
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    crop_t got;
    crop_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      got = {out_crop_width, out_crop_height, out_crop_left, out_crop_top};
      if (pending_crops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected crop: w=%0d h=%0d l=%0d t=%0d",
                   got.width, got.height, got.left, got.top);
      end else begin
        want = pending_crops.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("crop mismatch: want w=%0d h=%0d l=%0d t=%0d, got w=%0d h=%0d l=%0d t=%0d",
                     want.width, want.height, want.left, want.top,
                     got.width, got.height, got.left, got.top);
        end
      end
    end
  end

  // Result side: a fresh stall per item taken, plus an occasional long hold-off.
  always @(negedge clk) begin : result_pacing
    int stall_left;
    int drawn;
    int hold_seen;
    if (results_seen != drawn) begin
      drawn = results_seen;
      stall_left = receiver_quiet ? 0 : $urandom_range(0, 14);
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int j;
    int n;
    int random_items;
    logic [PIX_W-1:0] pr;
    logic [PIX_W-1:0] pg;
    logic [PIX_W-1:0] pb;
    logic [PIX_W-1:0] thr_pick;

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = REQ_PIXEL;
    in_red = '0;
    in_green = '0;
    in_blue = '0;

    thr = THRESHOLD_RESET;
    fw = WIDTH_RESET;
    fh = HEIGHT_RESET;
    restart_frame();
    reload_borders();

    // Reset borders of a 640 by 480 frame, then channel extremes around the threshold.
    put(STEP_REPORT, 0, 0, 0, 1'b1, 477, 81, 1);
    put(STEP_PIXEL, 0, 0, 0, 1'b0, 0, 0, 0);
    put(STEP_PIXEL, 255, 255, 255, 1'b0, 0, 0, 0);
    put(STEP_PIXEL, 200, 200, 200, 1'b0, 0, 0, 0);
    put(STEP_PIXEL, 201, 0, 0, 1'b0, 0, 0, 0);
    put(STEP_PIXEL, 0, 201, 0, 1'b0, 0, 0, 0);
    put(STEP_PIXEL, 0, 0, 201, 1'b0, 0, 0, 0);
    put(STEP_REPORT, 0, 0, 0, 1'b0, 0, 0, 0);
    // Zero sizes act as a one pixel frame, which gives a negative side.
    put(STEP_WRITE, CFG_WIDTH, 0, 0, 1'b0, 0, 0, 0);
    put(STEP_WRITE, CFG_HEIGHT, 0, 0, 1'b0, 0, 0, 0);
    put(STEP_REPORT, 0, 0, 0, 1'b1, -2, 1, 1);
    put(STEP_PIXEL, 0, 0, 0, 1'b0, 0, 0, 0);
    put(STEP_WRITE, CFG_THRESHOLD, 0, 0, 1'b0, 0, 0, 0);
    put(STEP_WRITE, CFG_WIDTH, 3, 0, 1'b0, 0, 0, 0);
    put(STEP_WRITE, CFG_HEIGHT, 3, 0, 1'b0, 0, 0, 0);
    put(STEP_REPORT, 0, 0, 0, 1'b1, 0, 1, 1);
    for (j = 0; j < 9; j++) begin
      if (j == 4 || j == 5) put(STEP_PIXEL, 1, 0, 0, 1'b0, 0, 0, 0);
      else put(STEP_PIXEL, 0, 0, 0, 1'b0, 0, 0, 0);
    end
    put(STEP_REPORT, 0, 0, 0, 1'b0, 0, 0, 0);
    // Oversized values saturate to the largest frame.
    put(STEP_WRITE, CFG_THRESHOLD, 255, 0, 1'b0, 0, 0, 0);
    put(STEP_WRITE, CFG_WIDTH, 4095, 0, 1'b0, 0, 0, 0);
    put(STEP_WRITE, CFG_HEIGHT, 4095, 0, 1'b0, 0, 0, 0);
    put(STEP_REPORT, 0, 0, 0, 1'b1, 2045, 1, 1);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      case (script[i].kind)
        STEP_WRITE: write_register(CFG_IDX_W'(script[i].a), SIZE_W'(script[i].b));
        STEP_PIXEL: send_item(REQ_PIXEL, PIX_W'(script[i].a), PIX_W'(script[i].b),
                              PIX_W'(script[i].c), 1'b0, '0);
        default: send_item(REQ_REPORT, '0, '0, '0, script[i].typed, script[i].want);
      endcase
    end

    // Full frames along a single long row, then down a single long column.
    write_register(CFG_THRESHOLD, SIZE_W'($urandom_range(20, 235)));
    write_register(CFG_WIDTH, SIZE_W'(FRAME_LEN));
    write_register(CFG_HEIGHT, 12'd1);
    sender_quiet = 1'b1;
    for (j = 0; j < 3; j++) begin
      if (j == 2) begin
        write_register(CFG_WIDTH, 12'd1);
        write_register(CFG_HEIGHT, SIZE_W'(FRAME_LEN));
      end
      repeat (FRAME_LEN) begin
        make_pixel(pr, pg, pb);
        send_item(REQ_PIXEL, pr, pg, pb, 1'b0, '0);
      end
      send_item(REQ_REPORT, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
    end

    // Hold the result side off while reports keep coming, so the input stalls.
    hold_req++;
    repeat (30) begin
      if ($urandom_range(0, 3) == 0) begin
        make_pixel(pr, pg, pb);
        send_item(REQ_PIXEL, pr, pg, pb, 1'b0, '0);
      end else begin
        send_item(REQ_REPORT, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
      end
    end
    wait_drained();
    sender_quiet = 1'b0;

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0: thr_pick = 8'h00;
          1: thr_pick = 8'hFF;
          default: thr_pick = PIX_W'($urandom);
        endcase
        write_register(CFG_THRESHOLD, {4'($urandom), thr_pick});
      end
      if ($urandom_range(0, 3) != 0) begin
        write_register(CFG_WIDTH, pick_size());
        write_register(CFG_HEIGHT, pick_size());
      end
      if ($urandom_range(0, 9) == 0) write_register(CFG_UNUSED, SIZE_W'($urandom));
      sender_quiet = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 90);
      for (j = 0; j < n; j++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(REQ_REPORT, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                    1'b0, '0);
        end else begin
          make_pixel(pr, pg, pb);
          send_item(REQ_PIXEL, pr, pg, pb, 1'b0, '0);
          if (col_pos == 0 && row_pos == 0 && $urandom_range(0, 1) == 1) begin
            send_item(REQ_REPORT, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                      1'b0, '0);
            random_items++;
          end
        end
        random_items++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    mismatches += pending_crops.size();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
